@@ src/stq_pkg.sv @@
`default_nettype none

package stq_pkg;

	// Sizing defaults
	localparam int MAX_TIMERS_DEF   = 16;
	localparam int RESULT_LIMIT     = 16;
	localparam int DEFAULT_DELAY_MS = 10;
	localparam int TPM_W            = 10;
	localparam int DELAY_W          = 32;
	localparam int TICK_W           = 64;
	localparam int SPAN_W           = DELAY_W + TPM_W;
	localparam int TAG_W            = 16;
	localparam logic [TPM_W-1:0] TPM_RESET = TPM_W'(1);

	// Input command codes
	localparam logic CMD_CREATE = 1'b0;
	localparam logic CMD_TICK   = 1'b1;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_CREATED  = 2'd0,
		KIND_REJECTED = 2'd1,
		KIND_EXPIRED  = 2'd2
	} kind_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADD,
		ST_SCAN,
		ST_PLACE,
		ST_RESP,
		ST_POP_RD,
		ST_POP_CHK
	} state_t;

	// One stored timer
	typedef struct packed {
		logic [TICK_W-1:0] expiry;
		logic [TAG_W-1:0]  ident;
		logic [TAG_W-1:0]  handler;
	} entry_t;

endpackage

`default_nettype wire

@@ src/sorted_timer_queue.sv @@
// Create: delay times ticks_per_ms (MUL), plus the tick (ADD), then a sorted insert shifts
//   each later entry back one slot (at most MAX_TIMERS - 1); a rejected create skips to RESP.
// Tick: each expired entry is read from memory (POP_RD), then compared and popped (POP_CHK);
//   done on an empty queue or at the result limit, else on the first entry not yet due.
// One item in flight at a time. Entry memory reads are registered; output stalls add waiting.
// Reset (arst_n low, async): queue empty, tick 0, ticks_per_ms 1; entry memory not cleared.
`default_nettype none

module sorted_timer_queue #(
	parameter int MAX_TIMERS = stq_pkg::MAX_TIMERS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// configuration write
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [stq_pkg::TPM_W-1:0]   cfg_data,
	// input items
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic                        cmd,
	input  wire logic [stq_pkg::DELAY_W-1:0] delay_ms,
	input  wire logic [stq_pkg::TAG_W-1:0]   timer_id,
	input  wire logic [stq_pkg::TAG_W-1:0]   handler_tag,
	// result items
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [1:0]                       kind,
	output logic [stq_pkg::TAG_W-1:0]        expired_id,
	output logic [stq_pkg::TAG_W-1:0]        expired_tag,
	output logic                             last
);

	localparam int IW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
	localparam int CW = $clog2(MAX_TIMERS + 1);
	localparam int SW = CW + 1;
	localparam int NW = $clog2(stq_pkg::RESULT_LIMIT + 1);
	localparam int TW = stq_pkg::TICK_W;

	// Physical slot of a queue offset in the circular buffer
	function automatic logic [IW-1:0] slot(input logic [IW-1:0] head, input logic [CW-1:0] off);
		logic [SW-1:0] sum;
		sum = SW'(head) + SW'(off);
		if (sum >= SW'(MAX_TIMERS))
			sum = sum - SW'(MAX_TIMERS);
		return sum[IW-1:0];
	endfunction

	stq_pkg::state_t state_q, state_d;

	logic [stq_pkg::TPM_W-1:0]   tpm_q;
	logic [TW-1:0]               now_q;
	logic [IW-1:0]               head_q;
	logic [CW-1:0]               count_q;
	logic [CW-1:0]               pos_q;
	logic [NW-1:0]               npop_q;
	logic                        have_q;
	logic [stq_pkg::TAG_W-1:0]   hold_id_q, hold_tag_q;
	logic [stq_pkg::DELAY_W-1:0] delay_q;
	logic [stq_pkg::TAG_W-1:0]   new_id_q, new_tag_q;
	logic [stq_pkg::SPAN_W-1:0]  span_q;
	logic [TW-1:0]               expiry_q;
	logic                        reject_q;

	stq_pkg::entry_t mem [MAX_TIMERS];
	stq_pkg::entry_t rd_q;

	logic                      out_valid_q;
	stq_pkg::kind_t            kind_q;
	logic [stq_pkg::TAG_W-1:0] id_q, tag_q;
	logic                      last_q;

	// Control decoded per state
	logic                      rd_en, wr_en, out_load, pop;
	logic [IW-1:0]             rd_addr, wr_addr;
	stq_pkg::entry_t           wr_data, new_entry;
	stq_pkg::kind_t            out_kind;
	logic [stq_pkg::TAG_W-1:0] out_id, out_tag;
	logic                      out_last;

	logic          in_acc, out_free, due, later, can_pop, full;
	logic [TW:0]   exp_sum;

	assign in_stall  = (state_q != stq_pkg::ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign due       = (rd_q.expiry <= now_q);
	assign later     = (rd_q.expiry > expiry_q);
	assign can_pop   = (count_q != '0) && (npop_q != NW'(stq_pkg::RESULT_LIMIT));
	assign full      = (count_q >= CW'(MAX_TIMERS));
	assign exp_sum   = {1'b0, now_q} + (TW+1)'(span_q);
	assign cfg_ready = 1'b1;

	assign new_entry.expiry  = expiry_q;
	assign new_entry.ident   = new_id_q;
	assign new_entry.handler = new_tag_q;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			stq_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (cmd == stq_pkg::CMD_TICK)
						state_d = stq_pkg::ST_POP_RD;
					else if (full)
						state_d = stq_pkg::ST_RESP;
					else
						state_d = stq_pkg::ST_MUL;
				end
			end
			stq_pkg::ST_MUL: state_d = stq_pkg::ST_ADD;
			stq_pkg::ST_ADD: begin
				state_d = (count_q == '0) ? stq_pkg::ST_PLACE : stq_pkg::ST_SCAN;
			end
			stq_pkg::ST_SCAN: begin
				if (!later)
					state_d = stq_pkg::ST_RESP;
				else if (pos_q == CW'(1))
					state_d = stq_pkg::ST_PLACE;
			end
			stq_pkg::ST_PLACE: state_d = stq_pkg::ST_RESP;
			stq_pkg::ST_RESP: begin
				if (out_free)
					state_d = stq_pkg::ST_IDLE;
			end
			stq_pkg::ST_POP_RD: begin
				if (can_pop)
					state_d = stq_pkg::ST_POP_CHK;
				else if (!have_q || out_free)
					state_d = stq_pkg::ST_IDLE;
			end
			stq_pkg::ST_POP_CHK: begin
				if (due) begin
					if (!have_q || out_free)
						state_d = stq_pkg::ST_POP_RD;
				end else if (!have_q || out_free) begin
					state_d = stq_pkg::ST_IDLE;
				end
			end
			default: state_d = stq_pkg::ST_IDLE;
		endcase
	end

	// Memory and output control
	always_comb begin
		rd_en    = 1'b0;
		rd_addr  = head_q;
		wr_en    = 1'b0;
		wr_addr  = head_q;
		wr_data  = new_entry;
		out_load = 1'b0;
		out_kind = stq_pkg::KIND_EXPIRED;
		out_id   = hold_id_q;
		out_tag  = hold_tag_q;
		out_last = 1'b0;
		pop      = 1'b0;
		case (state_q)
			stq_pkg::ST_ADD: begin
				// fetch the tail entry for the backward insert scan
				if (count_q != '0) begin
					rd_en   = 1'b1;
					rd_addr = slot(head_q, count_q - CW'(1));
				end
			end
			stq_pkg::ST_SCAN: begin
				if (later) begin
					// move the later entry one slot back, fetch the one before it
					wr_en   = 1'b1;
					wr_addr = slot(head_q, pos_q);
					wr_data = rd_q;
					if (pos_q != CW'(1)) begin
						rd_en   = 1'b1;
						rd_addr = slot(head_q, pos_q - CW'(2));
					end
				end else begin
					wr_en   = 1'b1;
					wr_addr = slot(head_q, pos_q);
				end
			end
			stq_pkg::ST_PLACE: begin
				wr_en   = 1'b1;
				wr_addr = head_q;
			end
			stq_pkg::ST_RESP: begin
				out_load = out_free;
				out_kind = reject_q ? stq_pkg::KIND_REJECTED : stq_pkg::KIND_CREATED;
				out_id   = new_id_q;
				out_tag  = new_tag_q;
				out_last = 1'b1;
			end
			stq_pkg::ST_POP_RD: begin
				if (can_pop) begin
					rd_en = 1'b1;
				end else if (have_q && out_free) begin
					out_load = 1'b1;
					out_last = 1'b1;
				end
			end
			stq_pkg::ST_POP_CHK: begin
				// held entry goes out once we know whether another follows
				if (due) begin
					pop      = !have_q || out_free;
					out_load = have_q && out_free;
				end else begin
					out_load = have_q && out_free;
					out_last = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= stq_pkg::ST_IDLE;
			tpm_q       <= stq_pkg::TPM_RESET;
			now_q       <= '0;
			head_q      <= '0;
			count_q     <= '0;
			npop_q      <= '0;
			have_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready)
				tpm_q <= cfg_data;
			if (in_acc && cmd == stq_pkg::CMD_TICK) begin
				now_q  <= now_q + TW'(1);
				npop_q <= '0;
				have_q <= 1'b0;
			end
			if ((state_q == stq_pkg::ST_SCAN && !later) || state_q == stq_pkg::ST_PLACE)
				count_q <= count_q + CW'(1);
			if (pop) begin
				head_q  <= (head_q == IW'(MAX_TIMERS - 1)) ? '0 : head_q + IW'(1);
				count_q <= count_q - CW'(1);
				npop_q  <= npop_q + NW'(1);
				have_q  <= 1'b1;
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_acc && cmd == stq_pkg::CMD_CREATE) begin
			delay_q   <= (delay_ms == '0) ? stq_pkg::DELAY_W'(stq_pkg::DEFAULT_DELAY_MS)
			                              : delay_ms;
			new_id_q  <= timer_id;
			new_tag_q <= handler_tag;
			reject_q  <= full;
		end
		if (state_q == stq_pkg::ST_MUL)
			span_q <= stq_pkg::SPAN_W'(delay_q) * stq_pkg::SPAN_W'(tpm_q);
		if (state_q == stq_pkg::ST_ADD) begin
			expiry_q <= exp_sum[TW] ? {TW{1'b1}} : exp_sum[TW-1:0];
			pos_q    <= count_q;
		end
		if (state_q == stq_pkg::ST_SCAN && later)
			pos_q <= pos_q - CW'(1);
		if (pop) begin
			hold_id_q  <= rd_q.ident;
			hold_tag_q <= rd_q.handler;
		end
		if (out_load) begin
			kind_q <= out_kind;
			id_q   <= out_id;
			tag_q  <= out_tag;
			last_q <= out_last;
		end
	end

	// Entry memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_q <= mem[rd_addr];
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign expired_id  = id_q;
	assign expired_tag = tag_q;
	assign last        = last_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_TIMERS))
		else $error("entry count above capacity");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("result loaded over a waiting one");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("pop from empty queue");
	a_scan_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == stq_pkg::ST_SCAN) |-> (pos_q != '0))
		else $error("insert scan past queue head");
`endif

endmodule

`default_nettype wire
